/* rtl/stq_pkg.sv */
// shared types, codes and the ordering function of the sorted timer queue
`default_nettype none

package stq_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int MAX_OUT     = 16;
	localparam int SLOT_W      = $clog2(TIMER_SLOTS);
	localparam int ROUND_W     = $clog2(TIMER_SLOTS);
	localparam int POP_W       = $clog2(MAX_OUT);
	localparam int TICK_W      = 32;
	localparam int RECV_W      = 8;
	localparam int AGE_W       = 8;
	localparam int FUNC_W      = 2;
	localparam int HANDLE_W    = 4;
	localparam int KIND_W      = 2;
	localparam int OUT_SLOT_W  = 4;
	localparam int DATA_W      = 48;

	localparam logic [FUNC_W-1:0] FUNC_ARM    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_ARMED     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXPIRED   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CANCELLED = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ERROR     = 2'd3;

	typedef enum logic [1:0] {
		SS_FREE    = 2'd0,
		SS_PENDING = 2'd1,
		SS_EXPIRED = 2'd2
	} slot_status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ARM,
		OP_CANCEL,
		OP_EXPIRE,
		OP_SORT
	} chain_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_SORT
	} fsm_state_t;

	typedef struct packed {
		slot_status_t        status;
		logic [SLOT_W-1:0]   slot;
		logic [TICK_W-1:0]   expiry;
		logic [RECV_W-1:0]   receiver;
		logic [AGE_W-1:0]    age;
	} entry_t;

	typedef struct packed {
		logic sort_right;
		logic sort_left;
		logic write;
		logic release_slot;
		logic expire;
		logic age_inc;
	} cell_ctl_t;

	typedef struct packed {
		chain_op_t           op;
		logic                parity;
		logic [RECV_W-1:0]   receiver;
		logic [TICK_W-1:0]   expiry;
		logic [HANDLE_W-1:0] handle;
	} chain_cmd_t;

	typedef struct packed {
		logic                free_any;
		logic [SLOT_W-1:0]   free_slot;
		logic                hit;
		logic [RECV_W-1:0]   hit_receiver;
		logic [TICK_W-1:0]   hit_expiry;
		logic                due_any;
		logic                due_single;
		logic [SLOT_W-1:0]   due_slot;
		logic [RECV_W-1:0]   due_receiver;
		logic [TICK_W-1:0]   due_expiry;
	} chain_stat_t;

	// pending entries first: earliest expiry, then oldest, then lowest slot
	function automatic logic stq_less(entry_t a, entry_t b);
		logic r;
		r = 1'b0;
		if (a.status == SS_PENDING) begin
			if (b.status != SS_PENDING) begin
				r = 1'b1;
			end else if (a.expiry != b.expiry) begin
				r = a.expiry < b.expiry;
			end else if (a.age != b.age) begin
				r = a.age > b.age;
			end else begin
				r = a.slot < b.slot;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/sorted_timer_queue.sv */
// sorted timer queue: one-shot timers kept ordered by expiry in a chain of cells
// cancel: result loaded as the word is accepted; the next word waits until it is taken
// arm: result loaded as the word is accepted; if a slot was free, TIMER_SLOTS odd-even
//   swap rounds run along the chain before the next word is accepted
// tick: one result word per cycle while the result side is free, earliest due cell first
// reset: all slots free, tick counter zero, no result pending; no clearing pass
`default_nettype none

module sorted_timer_queue
	import stq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // receiver[7:0], when[39:8], handle[43:40]
	input  logic [FUNC_W-1:0] s_tuser,   // func[1:0]
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // slot[3:0], target[11:4], expiry[43:12]
	output logic [KIND_W-1:0] m_tuser,   // kind[1:0]
	output logic              m_tlast
);

	fsm_state_t              state_q, state_nxt;
	logic [TICK_W-1:0]       tick_q;
	logic [ROUND_W-1:0]      round_q;
	logic [POP_W-1:0]        pop_cnt_q;
	logic                    out_valid_q;
	logic [KIND_W-1:0]       out_kind_q;
	logic [OUT_SLOT_W-1:0]   out_slot_q;
	logic [RECV_W-1:0]       out_target_q;
	logic [TICK_W-1:0]       out_expiry_q;
	logic                    out_last_q;

	logic [RECV_W-1:0]       in_receiver;
	logic [TICK_W-1:0]       in_when;
	logic [HANDLE_W-1:0]     in_handle;
	logic                    in_acc;
	logic                    out_free;
	logic                    out_load;
	logic [KIND_W-1:0]       out_kind;
	logic [OUT_SLOT_W-1:0]   out_slot;
	logic [RECV_W-1:0]       out_target;
	logic [TICK_W-1:0]       out_expiry;
	logic                    out_last;
	logic                    tick_inc;
	logic                    round_clr;
	logic                    round_inc;
	logic                    pop_clr;
	logic                    pop_inc;
	chain_cmd_t              cmd;
	chain_stat_t             stat;

	assign in_receiver = s_tdata[7:0];
	assign in_when     = s_tdata[39:8];
	assign in_handle   = s_tdata[43:40];
	assign in_acc      = s_tvalid && s_tready;
	assign out_free    = !out_valid_q || m_tready;

	stq_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.tick   (tick_q),
		.stat   (stat)
	);

	always_comb begin
		state_nxt    = state_q;
		s_tready     = 1'b0;
		out_load     = 1'b0;
		out_kind     = KIND_ERROR;
		out_slot     = '0;
		out_target   = '0;
		out_expiry   = '0;
		out_last     = 1'b1;
		tick_inc     = 1'b0;
		round_clr    = 1'b0;
		round_inc    = 1'b0;
		pop_clr      = 1'b0;
		pop_inc      = 1'b0;
		cmd          = '0;
		cmd.op       = OP_NONE;
		cmd.parity   = round_q[0];
		cmd.receiver = in_receiver;
		cmd.expiry   = in_when;
		cmd.handle   = in_handle;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = out_free;
				if (in_acc) begin
					unique case (s_tuser)
						FUNC_ARM: begin
							cmd.op   = OP_ARM;
							out_load = 1'b1;
							if (stat.free_any) begin
								out_kind   = KIND_ARMED;
								out_slot   = OUT_SLOT_W'(stat.free_slot);
								out_target = in_receiver;
								out_expiry = in_when;
								round_clr  = 1'b1;
								state_nxt  = ST_SORT;
							end
						end
						FUNC_CANCEL: begin
							cmd.op   = OP_CANCEL;
							out_load = 1'b1;
							out_slot = OUT_SLOT_W'(in_handle);
							if (stat.hit) begin
								out_kind   = KIND_CANCELLED;
								out_target = stat.hit_receiver;
								out_expiry = stat.hit_expiry;
							end
						end
						FUNC_TICK: begin
							tick_inc  = 1'b1;
							pop_clr   = 1'b1;
							state_nxt = ST_POP;
						end
						default: begin
							state_nxt = ST_IDLE;
						end
					endcase
				end
			end
			ST_POP: begin
				// pending cells stay in expiry order, so the first due cell is the earliest pending one
				if (!stat.due_any) begin
					state_nxt = ST_IDLE;
				end else if (out_free) begin
					cmd.op     = OP_EXPIRE;
					out_load   = 1'b1;
					out_kind   = KIND_EXPIRED;
					out_slot   = OUT_SLOT_W'(stat.due_slot);
					out_target = stat.due_receiver;
					out_expiry = stat.due_expiry;
					out_last   = stat.due_single || pop_cnt_q == POP_W'(MAX_OUT - 1);
					pop_inc    = 1'b1;
					if (out_last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_SORT: begin
				cmd.op    = OP_SORT;
				round_inc = 1'b1;
				if (round_q == ROUND_W'(TIMER_SLOTS - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= '0;
			round_q     <= '0;
			pop_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (tick_inc) begin
				tick_q <= tick_q + 1'b1;
			end
			if (round_clr) begin
				round_q <= '0;
			end else if (round_inc) begin
				round_q <= round_q + 1'b1;
			end
			if (pop_clr) begin
				pop_cnt_q <= '0;
			end else if (pop_inc) begin
				pop_cnt_q <= pop_cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q   <= out_kind;
			out_slot_q   <= out_slot;
			out_target_q <= out_target;
			out_expiry_q <= out_expiry;
			out_last_q   <= out_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(DATA_W - OUT_SLOT_W - RECV_W - TICK_W)'(0), out_expiry_q,
		out_target_q, out_slot_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

/* rtl/stq_cell.sv */
// one timer cell of the chain: holds an entry, swaps with a neighbor on sort rounds
`default_nettype none

module stq_cell
	import stq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] home,
	input  cell_ctl_t         ctl,
	input  logic [RECV_W-1:0] wr_receiver,
	input  logic [TICK_W-1:0] wr_expiry,
	input  entry_t            left,
	input  entry_t            right,
	output entry_t            ent
);

	slot_status_t      status_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TICK_W-1:0] expiry_q;
	logic [RECV_W-1:0] receiver_q;
	logic [AGE_W-1:0]  age_q;
	entry_t            cur;
	entry_t            nxt;

	assign cur.status   = status_q;
	assign cur.slot     = slot_q;
	assign cur.expiry   = expiry_q;
	assign cur.receiver = receiver_q;
	assign cur.age      = age_q;
	assign ent          = cur;

	always_comb begin
		nxt = cur;
		priority if (ctl.sort_right && stq_less(right, cur)) begin
			nxt = right;
		end else if (ctl.sort_left && stq_less(cur, left)) begin
			nxt = left;
		end else if (ctl.write) begin
			nxt.status   = SS_PENDING;
			nxt.expiry   = wr_expiry;
			nxt.receiver = wr_receiver;
			nxt.age      = '0;
		end else if (ctl.release_slot) begin
			nxt.status = SS_FREE;
		end else if (ctl.expire) begin
			nxt.status = SS_EXPIRED;
		end else if (ctl.age_inc && cur.status != SS_FREE && cur.age != '1) begin
			nxt.age = cur.age + 1'b1;
		end else begin
			nxt = cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= SS_FREE;
			slot_q   <= home;
		end else begin
			status_q <= nxt.status;
			slot_q   <= nxt.slot;
		end
	end

	always_ff @(posedge clk) begin
		expiry_q   <= nxt.expiry;
		receiver_q <= nxt.receiver;
		age_q      <= nxt.age;
	end

endmodule

`default_nettype wire

/* rtl/stq_chain.sv */
// row of timer cells with free-slot, handle and due lookups over the row
`default_nettype none

module stq_chain
	import stq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  chain_cmd_t        cmd,
	input  logic [TICK_W-1:0] tick,
	output chain_stat_t       stat
);

	entry_t                 ent [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] free_by_slot;
	logic [TIMER_SLOTS-1:0] free_first;
	logic [TIMER_SLOTS-1:0] hit_vec;
	logic [TIMER_SLOTS-1:0] due_vec;
	logic [TIMER_SLOTS-1:0] due_first;
	logic [SLOT_W-1:0]      free_slot;
	logic                   free_any;

	always_comb begin
		free_by_slot = '0;
		hit_vec      = '0;
		due_vec      = '0;
		for (int c = 0; c < TIMER_SLOTS; c++) begin
			if (ent[c].status == SS_FREE) begin
				free_by_slot[ent[c].slot] = 1'b1;
			end
			if (ent[c].status != SS_FREE && 32'(ent[c].slot) == 32'(cmd.handle)) begin
				hit_vec[c] = 1'b1;
			end
			if (ent[c].status == SS_PENDING && ent[c].expiry <= tick) begin
				due_vec[c] = 1'b1;
			end
		end
	end

	// lowest set bit
	assign free_first = free_by_slot & (~free_by_slot + 1'b1);
	assign due_first  = due_vec & (~due_vec + 1'b1);
	assign free_any   = |free_by_slot;

	always_comb begin
		free_slot = '0;
		for (int c = 0; c < TIMER_SLOTS; c++) begin
			if (free_first[c]) begin
				free_slot = SLOT_W'(c);
			end
		end
	end

	always_comb begin
		stat            = '0;
		stat.free_any   = free_any;
		stat.free_slot  = free_slot;
		stat.hit        = |hit_vec;
		stat.due_any    = |due_vec;
		stat.due_single = (due_vec & (due_vec - 1'b1)) == '0;
		for (int c = 0; c < TIMER_SLOTS; c++) begin
			if (hit_vec[c]) begin
				stat.hit_receiver = ent[c].receiver;
				stat.hit_expiry   = ent[c].expiry;
			end
			if (due_first[c]) begin
				stat.due_slot     = ent[c].slot;
				stat.due_receiver = ent[c].receiver;
				stat.due_expiry   = ent[c].expiry;
			end
		end
	end

	for (genvar c = 0; c < TIMER_SLOTS; c++) begin : g_cell
		localparam bit ODD   = (c % 2) == 1;
		localparam bit FIRST = c == 0;
		localparam bit LAST  = c == TIMER_SLOTS - 1;
		entry_t    left_ent;
		entry_t    right_ent;
		cell_ctl_t cctl;

		if (FIRST) begin : g_left_edge
			assign left_ent = ent[c];
		end else begin : g_left
			assign left_ent = ent[c-1];
		end

		if (LAST) begin : g_right_edge
			assign right_ent = ent[c];
		end else begin : g_right
			assign right_ent = ent[c+1];
		end

		// even rounds pair cells 0-1, 2-3 ..., odd rounds pair 1-2, 3-4 ...
		always_comb begin
			cctl              = '0;
			cctl.sort_right   = cmd.op == OP_SORT && ODD == cmd.parity && !LAST;
			cctl.sort_left    = cmd.op == OP_SORT && ODD != cmd.parity && !FIRST;
			cctl.write        = cmd.op == OP_ARM && free_any && ent[c].slot == free_slot;
			cctl.age_inc      = cmd.op == OP_ARM && free_any;
			cctl.release_slot = cmd.op == OP_CANCEL && hit_vec[c];
			cctl.expire       = cmd.op == OP_EXPIRE && due_first[c];
		end

		stq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.home        (SLOT_W'(c)),
			.ctl         (cctl),
			.wr_receiver (cmd.receiver),
			.wr_expiry   (cmd.expiry),
			.left        (left_ent),
			.right       (right_ent),
			.ent         (ent[c])
		);
	end

endmodule

`default_nettype wire

/* tb/sorted_timer_queue_test.sv */
// self-checking testbench for the sorted timer queue: arm, cancel and tick words against a predictor
`timescale 1ns / 1ps

module sorted_timer_queue_test;
	import stq_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_WORDS = 390;

	typedef struct {
		logic [FUNC_W-1:0]   func;
		logic [RECV_W-1:0]   receiver;
		logic [TICK_W-1:0]   when;
		logic [HANDLE_W-1:0] handle;
	} timer_call_t;

	typedef struct {
		logic [KIND_W-1:0]     kind;
		logic [OUT_SLOT_W-1:0] slot;
		logic [RECV_W-1:0]     target;
		logic [TICK_W-1:0]     expiry;
		logic                  last;
	} timer_event_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;    // receiver[7:0], when[39:8], handle[43:40]
	logic [FUNC_W-1:0] s_tuser = '0;    // func[1:0]
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;         // slot[3:0], target[11:4], expiry[43:12]
	logic [KIND_W-1:0] m_tuser;         // kind[1:0]
	logic              m_tlast;

	// predicted timer table
	logic [TICK_W-1:0] now_tick;
	slot_status_t      slot_state     [TIMER_SLOTS];
	logic [TICK_W-1:0] slot_when      [TIMER_SLOTS];
	logic [RECV_W-1:0] slot_owner     [TIMER_SLOTS];
	logic [AGE_W-1:0]  slot_seniority [TIMER_SLOTS];

	timer_call_t  call_queue[$];
	timer_event_t owed_results[$];
	timer_call_t  on_bus;
	timer_event_t want;

	int idle_phase = 0;
	int send_gap_pct;
	int recv_gap_pct;
	int words_accepted = 0;
	int stall_from = 32'h7fffffff;
	int stall_left;
	logic stall_done;
	int failures = 0;
	int cycles = 0;
	int kinds_seen [4] = '{0, 0, 0, 0};

	assign send_gap_pct = (idle_phase == 0) ? 19 : (idle_phase == 1) ? 58 : 0;
	assign recv_gap_pct = (idle_phase == 0) ? 58 : (idle_phase == 1) ? 19 : 0;

	sorted_timer_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// apply one accepted call to the table and queue the results it owes
	function automatic void predict_timer_call(timer_call_t c);
		int free_idx;
		int best;
		int fired;
		timer_event_t ev;
		free_idx = -1;
		fired = 0;
		ev = '{default: '0};
		case (c.func)
			FUNC_ARM: begin
				for (int i = TIMER_SLOTS - 1; i >= 0; i--)
					if (slot_state[i] == SS_FREE) free_idx = i;
				ev.last = 1'b1;
				if (free_idx < 0) begin
					ev.kind = KIND_ERROR;
				end else begin
					for (int i = 0; i < TIMER_SLOTS; i++)
						if (slot_state[i] != SS_FREE && slot_seniority[i] != '1)
							slot_seniority[i]++;
					slot_state[free_idx] = SS_PENDING;
					slot_when[free_idx] = c.when;
					slot_owner[free_idx] = c.receiver;
					slot_seniority[free_idx] = '0;
					ev.kind = KIND_ARMED;
					ev.slot = OUT_SLOT_W'(free_idx);
					ev.target = c.receiver;
					ev.expiry = c.when;
				end
				owed_results.push_back(ev);
			end
			FUNC_CANCEL: begin
				ev.last = 1'b1;
				ev.slot = c.handle;
				if (slot_state[c.handle] == SS_FREE) begin
					ev.kind = KIND_ERROR;
				end else begin
					ev.kind = KIND_CANCELLED;
					ev.target = slot_owner[c.handle];
					ev.expiry = slot_when[c.handle];
					slot_state[c.handle] = SS_FREE;
				end
				owed_results.push_back(ev);
			end
			FUNC_TICK: begin
				now_tick++;
				while (fired < MAX_OUT) begin
					best = -1;
					for (int i = 0; i < TIMER_SLOTS; i++) begin
						if (slot_state[i] == SS_PENDING && slot_when[i] <= now_tick) begin
							if (best < 0 || slot_when[i] < slot_when[best] ||
							    (slot_when[i] == slot_when[best] &&
							     slot_seniority[i] > slot_seniority[best]))
								best = i;
						end
					end
					if (best < 0) break;
					slot_state[best] = SS_EXPIRED;
					ev.kind = KIND_EXPIRED;
					ev.slot = OUT_SLOT_W'(best);
					ev.target = slot_owner[best];
					ev.expiry = slot_when[best];
					ev.last = 1'b0;
					owed_results.push_back(ev);
					fired++;
				end
				if (fired > 0) begin
					ev = owed_results.pop_back();
					ev.last = 1'b1;
					owed_results.push_back(ev);
				end
			end
			default: begin
				// unused function code: no result, table untouched
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] got);
		if (exp_val !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, got);
			failures++;
		end
	endfunction

	task automatic offer(logic [FUNC_W-1:0] f, logic [RECV_W-1:0] r, logic [TICK_W-1:0] w,
	                     logic [HANDLE_W-1:0] h);
		timer_call_t c;
		c.func = f;
		c.receiver = r;
		c.when = w;
		c.handle = h;
		while (call_queue.size() >= 2) @(negedge clk);
		call_queue.push_back(c);
	endtask

	task automatic settle();
		while (call_queue.size() != 0 || s_tvalid || owed_results.size() != 0)
			@(negedge clk);
	endtask

	// driver: predicts each word as it is accepted, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			words_accepted <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_timer_call(on_bus);
				words_accepted <= words_accepted + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (call_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					on_bus = call_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, on_bus.handle, on_bus.when, on_bus.receiver};
					s_tuser <= on_bus.func;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result side backpressure, with one long hold-off to fill the block
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
			stall_done <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!stall_done && words_accepted >= stall_from) begin
			stall_done <= 1'b1;
			stall_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_results.size() == 0) begin
				$error("unexpected result word: kind %0d slot %0d", m_tuser, m_tdata[3:0]);
				failures++;
			end else begin
				want = owed_results.pop_front();
				check_field("kind", want.kind, m_tuser);
				check_field("slot", want.slot, m_tdata[3:0]);
				check_field("target", want.target, m_tdata[11:4]);
				check_field("expiry", want.expiry, m_tdata[43:12]);
				check_field("last", want.last, m_tlast);
				kinds_seen[m_tuser]++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed", cycles,
			         owed_results.size());
			$display("** sorted_timer_queue: FAILED **");
			$finish;
		end
	end

	initial begin
		int busy[$];
		int r;
		logic [TICK_W-1:0] due;
		logic [HANDLE_W-1:0] h;

		now_tick = '0;
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			slot_state[i] = SS_FREE;
			slot_when[i] = '0;
			slot_owner[i] = '0;
			slot_seniority[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty tick, ignored code, free-slot cancel, extremes, ties
		offer(FUNC_TICK, 8'h00, 32'h0, 4'h0);
		offer(2'd3, 8'($urandom), $urandom, 4'($urandom));
		offer(FUNC_CANCEL, 8'h00, 32'h0, 4'h5);
		offer(FUNC_ARM, 8'h00, 32'h0000_0000, 4'h0);
		offer(FUNC_ARM, 8'hff, 32'hffff_ffff, 4'hf);
		offer(FUNC_ARM, 8'ha5, 32'd3, 4'h0);
		offer(FUNC_ARM, 8'h5a, 32'd3, 4'h0);
		repeat (3) offer(FUNC_TICK, 8'h00, 32'h0, 4'h0);
		offer(FUNC_CANCEL, 8'h00, 32'h0, 4'h0);
		offer(FUNC_CANCEL, 8'h00, 32'h0, 4'h1);
		offer(FUNC_CANCEL, 8'h00, 32'h0, 4'h1);
		// fill the table, most timers due on the same tick, then one arm too many
		for (int i = 0; i < TIMER_SLOTS - 2; i++)
			offer(FUNC_ARM, 8'($urandom), (i % 5 == 4) ? $urandom : 32'd4, 4'h0);
		offer(FUNC_ARM, 8'h3c, 32'd9, 4'h0);
		offer(FUNC_TICK, 8'h00, 32'h0, 4'h0);
		offer(FUNC_CANCEL, 8'h00, 32'h0, 4'hf);

		// random traffic, mostly near-term timers so ticks keep releasing them
		settle();
		idle_phase = 1;
		stall_from = words_accepted + 60;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 2) idle_phase = 2;
			r = $urandom_range(99);
			if (r < 30) begin
				case ($urandom_range(6))
					0: due = $urandom;
					1: due = now_tick - $urandom_range(3);
					default: due = now_tick + $urandom_range(6);
				endcase
				offer(FUNC_ARM, 8'($urandom), due, 4'h0);
			end else if (r < 55) begin
				busy = {};
				for (int i = 0; i < TIMER_SLOTS; i++)
					if (slot_state[i] != SS_FREE) busy.push_back(i);
				if (busy.size() != 0 && $urandom_range(4) != 0)
					h = HANDLE_W'(busy[$urandom_range(busy.size() - 1)]);
				else
					h = 4'($urandom);
				offer(FUNC_CANCEL, 8'($urandom), $urandom, h);
			end else if (r < 95) begin
				offer(FUNC_TICK, 8'($urandom), $urandom, 4'($urandom));
			end else begin
				offer(2'd3, 8'($urandom), $urandom, 4'($urandom));
			end
		end

		settle();
		repeat (40) @(negedge clk);
		$display("%0d words accepted over %0d ticks: %0d armed, %0d expired, %0d cancelled",
		         words_accepted, now_tick, kinds_seen[KIND_ARMED], kinds_seen[KIND_EXPIRED],
		         kinds_seen[KIND_CANCELLED]);
		$display("%0d refused (table full or slot free), one long result hold-off of %0d cycles",
		         kinds_seen[KIND_ERROR], HOLD_CYCLES);
		if (failures == 0 && owed_results.size() == 0) begin
			$display("** sorted_timer_queue: PASSED **");
		end else begin
			$display("%0d failures, %0d results never arrived", failures, owed_results.size());
			$display("** sorted_timer_queue: FAILED **");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/stq_chain.sv
rtl/sorted_timer_queue.sv
tb/sorted_timer_queue_test.sv
